### rtl/brrq_pkg.sv
package brrq_pkg;

  // store and record geometry
  localparam int RING_BYTES   = 1024;
  localparam int RECORD_BYTES = 8;
  localparam int BYTE_W       = 8;
  localparam int REC_W        = BYTE_W * RECORD_BYTES;
  localparam int DATA_W       = 64;
  localparam int CFG_W        = 11;
  localparam int PTR_W        = $clog2(RING_BYTES);
  localparam int SIZE_W       = PTR_W + 1;
  localparam int CNT_W        = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

  // operation codes on in_op
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP,
    S_POP_TAIL,
    S_DONE
  } state_t;

  // byte shifter control
  typedef struct packed {
    logic load;
    logic shift;
  } shift_ctrl_t;

endpackage

### rtl/byte_ring_record_queue.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+-----------------------------------------------
// in       | in_valid / in_ready    | in_op, in_record_data
// out      | out_valid / out_ready  | out_status, out_popped_record, out_is_empty,
//          |                        | out_free_bytes
// cfg      | cfg_wr_en              | cfg_wr_data
//
// A push moves one byte a cycle into the single-port ring RAM; out_valid rises as the
// item leaves S_DONE and in_ready returns with it. A pop reads one byte a cycle from
// the registered RAM read, through S_POP and then S_POP_TAIL. A refused item goes
// straight from S_IDLE to S_DONE. A new item is taken only in S_IDLE, once the last
// one has left S_DONE. The single RAM port and the byte shifter set this pace.
// rst_n (synchronous) empties the queue and sets the ring length to the whole store;
// RAM contents are not cleared. One finished item may wait in the output register
// while the next item is taken and worked on; that item then holds in its final
// state until the output register frees.
module byte_ring_record_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [brrq_pkg::DATA_W-1:0]  in_record_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [brrq_pkg::DATA_W-1:0]  out_popped_record,
  output logic                         out_is_empty,
  output logic [brrq_pkg::CFG_W-1:0]   out_free_bytes,
  input  logic                         cfg_wr_en,
  input  logic [brrq_pkg::CFG_W-1:0]   cfg_wr_data
);

  brrq_pkg::state_t                 state_r, state_nxt;
  logic [brrq_pkg::PTR_W-1:0]       head_r, head_nxt;
  logic [brrq_pkg::PTR_W-1:0]       tail_r, tail_nxt;
  logic                             full_r, full_nxt;
  logic [brrq_pkg::SIZE_W-1:0]      size_r, size_nxt;
  logic [brrq_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             rd_pend_r;
  brrq_pkg::op_t                    op_r;
  brrq_pkg::status_t                status_r, status_nxt;

  logic                             out_valid_r, out_valid_nxt;
  brrq_pkg::status_t                out_status_r;
  logic [brrq_pkg::DATA_W-1:0]      out_popped_r;
  logic                             out_empty_r;
  logic [brrq_pkg::CFG_W-1:0]       out_free_r;

  logic                             in_fire;
  logic                             out_load;
  logic                             cnt_last;
  logic                             empty_now;
  logic [brrq_pkg::SIZE_W-1:0]      free_now;
  logic                             push_ok;
  logic                             pop_ok;
  logic [brrq_pkg::SIZE_W-1:0]      head_inc;
  logic [brrq_pkg::SIZE_W-1:0]      tail_inc;
  logic [brrq_pkg::PTR_W-1:0]       head_adv;
  logic [brrq_pkg::PTR_W-1:0]       tail_adv;
  logic [brrq_pkg::SIZE_W-1:0]      cfg_size;

  logic                             ram_we;
  logic [brrq_pkg::PTR_W-1:0]       ram_addr;
  logic [brrq_pkg::BYTE_W-1:0]      ram_wdata;
  logic [brrq_pkg::BYTE_W-1:0]      ram_rdata;

  brrq_pkg::shift_ctrl_t            sh_ctrl;
  logic [brrq_pkg::REC_W-1:0]       sh_load_data;
  logic [brrq_pkg::BYTE_W-1:0]      sh_byte_in;
  logic [brrq_pkg::REC_W-1:0]       sh_q;

  assign in_fire  = in_valid && in_ready;
  assign cnt_last = (cnt_r == brrq_pkg::CNT_W'(brrq_pkg::RECORD_BYTES - 1));

  // occupancy from the current pointers
  assign empty_now = !full_r && (head_r == tail_r);
  always_comb begin
    if (full_r) begin
      free_now = '0;
    end else if (head_r <= tail_r) begin
      free_now = size_r - brrq_pkg::SIZE_W'(tail_r - head_r);
    end else begin
      free_now = brrq_pkg::SIZE_W'(head_r - tail_r - brrq_pkg::PTR_W'(1));
    end
  end

  assign push_ok = (free_now >= brrq_pkg::SIZE_W'(brrq_pkg::RECORD_BYTES));
  assign pop_ok  = !empty_now;

  // pointer advance with wrap at the ring length
  assign head_inc = brrq_pkg::SIZE_W'(head_r) + brrq_pkg::SIZE_W'(1);
  assign tail_inc = brrq_pkg::SIZE_W'(tail_r) + brrq_pkg::SIZE_W'(1);
  assign head_adv = (head_inc >= size_r) ? '0 : head_inc[brrq_pkg::PTR_W-1:0];
  assign tail_adv = (tail_inc >= size_r) ? '0 : tail_inc[brrq_pkg::PTR_W-1:0];

  // ring length saturates at the store size
  assign cfg_size = (brrq_pkg::SIZE_W'(cfg_wr_data) > brrq_pkg::SIZE_W'(brrq_pkg::RING_BYTES))
                  ? brrq_pkg::SIZE_W'(brrq_pkg::RING_BYTES)
                  : brrq_pkg::SIZE_W'(cfg_wr_data);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brrq_pkg::S_IDLE: begin
        if (in_fire) begin
          if (brrq_pkg::op_t'(in_op) == brrq_pkg::OP_PUSH) begin
            state_nxt = push_ok ? brrq_pkg::S_PUSH : brrq_pkg::S_DONE;
          end else begin
            state_nxt = pop_ok ? brrq_pkg::S_POP : brrq_pkg::S_DONE;
          end
        end
      end
      brrq_pkg::S_PUSH: begin
        if (cnt_last) state_nxt = brrq_pkg::S_DONE;
      end
      brrq_pkg::S_POP: begin
        if (cnt_last) state_nxt = brrq_pkg::S_POP_TAIL;
      end
      brrq_pkg::S_POP_TAIL: begin
        state_nxt = brrq_pkg::S_DONE;
      end
      brrq_pkg::S_DONE: begin
        if (out_load) state_nxt = brrq_pkg::S_IDLE;
      end
      default: state_nxt = brrq_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = head_r;
    out_load      = 1'b0;
    sh_ctrl.load  = 1'b0;
    sh_ctrl.shift = rd_pend_r;
    unique case (state_r)
      brrq_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        sh_ctrl.load = in_valid;
      end
      brrq_pkg::S_PUSH: begin
        ram_we        = 1'b1;
        ram_addr      = tail_r;
        sh_ctrl.shift = 1'b1;
      end
      brrq_pkg::S_POP: begin
        ram_addr = head_r;
      end
      brrq_pkg::S_POP_TAIL: begin
        ram_addr = head_r;
      end
      brrq_pkg::S_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // only an accepted push carries its record into the shifter; otherwise it starts clear
  assign sh_load_data = ((brrq_pkg::op_t'(in_op) == brrq_pkg::OP_PUSH) && push_ok)
                      ? in_record_data[brrq_pkg::REC_W-1:0] : '0;
  assign sh_byte_in   = rd_pend_r ? ram_rdata : '0;

  // pointer, mark, counter and status updates
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    full_nxt   = full_r;
    size_nxt   = size_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    if (cfg_wr_en) begin
      size_nxt = cfg_size;
      head_nxt = '0;
      tail_nxt = '0;
      full_nxt = 1'b0;
    end else if (in_fire) begin
      cnt_nxt = '0;
      if (brrq_pkg::op_t'(in_op) == brrq_pkg::OP_PUSH) begin
        status_nxt = push_ok ? brrq_pkg::ST_OK : brrq_pkg::ST_NO_SPACE;
        if (free_now == brrq_pkg::SIZE_W'(brrq_pkg::RECORD_BYTES)) full_nxt = 1'b1;
      end else begin
        status_nxt = pop_ok ? brrq_pkg::ST_OK : brrq_pkg::ST_EMPTY;
        if (pop_ok) full_nxt = 1'b0;
      end
    end else if (state_r == brrq_pkg::S_PUSH) begin
      tail_nxt = tail_adv;
      cnt_nxt  = cnt_r + brrq_pkg::CNT_W'(1);
    end else if (state_r == brrq_pkg::S_POP) begin
      head_nxt = head_adv;
      cnt_nxt  = cnt_r + brrq_pkg::CNT_W'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brrq_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      full_r      <= 1'b0;
      size_r      <= brrq_pkg::SIZE_W'(brrq_pkg::RING_BYTES);
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      full_r      <= full_nxt;
      size_r      <= size_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= (state_r == brrq_pkg::S_POP);
      out_valid_r <= out_valid_nxt;
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (in_fire) begin
      op_r <= brrq_pkg::op_t'(in_op);
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_popped_r <= brrq_pkg::DATA_W'(sh_q);
      out_empty_r  <= empty_now;
      out_free_r   <= brrq_pkg::CFG_W'(free_now);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_popped_record = out_popped_r;
  assign out_is_empty      = out_empty_r;
  assign out_free_bytes    = out_free_r;

  // ring store
  brrq_ram #(
    .WIDTH (brrq_pkg::BYTE_W),
    .DEPTH (brrq_pkg::RING_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // record shifter: bytes out on push, bytes in on pop
  brrq_shifter u_shifter (
    .clk       (clk),
    .ctrl      (sh_ctrl),
    .load_data (sh_load_data),
    .byte_in   (sh_byte_in),
    .byte_out  (ram_wdata),
    .q         (sh_q)
  );

`ifndef SYNTHESIS
  // read data is only captured during a pop
  a_rd_pend_pop: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == brrq_pkg::S_POP || state_r == brrq_pkg::S_POP_TAIL))
    else $error("ring read captured outside a pop");

  // a refused push leaves the tail alone
  a_refused_push_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_wr_en && (brrq_pkg::op_t'(in_op) == brrq_pkg::OP_PUSH) && !push_ok)
    |=> (tail_r == $past(tail_r)))
    else $error("tail moved on a refused push");

  // after a push every byte has left the shifter
  a_push_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == brrq_pkg::S_DONE && op_r == brrq_pkg::OP_PUSH) |-> (sh_q == '0))
    else $error("record bytes left in shifter after push");

  // a waiting result only leaves through a handshake
  a_out_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && $past(out_valid_r) && !$past(out_ready)) |-> 1'b0)
    else $error("result dropped without handshake");
`endif

endmodule

### rtl/brrq_ram.sv
module brrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/brrq_shifter.sv
module brrq_shifter (
  input  logic                               clk,
  input  brrq_pkg::shift_ctrl_t              ctrl,
  input  logic [brrq_pkg::REC_W-1:0]         load_data,
  input  logic [brrq_pkg::BYTE_W-1:0]        byte_in,
  output logic [brrq_pkg::BYTE_W-1:0]        byte_out,
  output logic [brrq_pkg::REC_W-1:0]         q
);

  logic [brrq_pkg::REC_W-1:0] q_r;
  logic [brrq_pkg::REC_W-1:0] q_nxt;

  // byte-wide shift right; new byte enters at the top, byte 0 leaves at the bottom
  always_comb begin
    q_nxt = q_r;
    if (ctrl.load) begin
      q_nxt = load_data;
    end else if (ctrl.shift) begin
      q_nxt = (q_r >> brrq_pkg::BYTE_W)
            | (brrq_pkg::REC_W'(byte_in) << (brrq_pkg::REC_W - brrq_pkg::BYTE_W));
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign byte_out = q_r[brrq_pkg::BYTE_W-1:0];
  assign q        = q_r;

endmodule

### test/byte_ring_record_queue_test.sv
module byte_ring_record_queue_test;
  import brrq_pkg::*;

  localparam int NUM_PHASES = 16;
  localparam int RING_PLAN [NUM_PHASES] = '{1024, 8, 9, 16, 12, 17, 24, 25, 0, 3, 40, 2047,
                                            1023, 64, 33, 0};

  typedef struct {
    op_t         op;
    logic [63:0] data;
  } ring_op_t;

  typedef struct {
    status_t     status;
    logic [63:0] rec;
    logic        empty;
    logic [10:0] freeb;
  } ring_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_op = 1'b0;
  logic [DATA_W-1:0] in_record_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [DATA_W-1:0] out_popped_record;
  logic              out_is_empty;
  logic [CFG_W-1:0]  out_free_bytes;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;

  // items waiting to be driven, results waiting to arrive
  ring_op_t     pending_ops [$];
  ring_result_t expected_results [$];

  logic in_took = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_mode = 0;
  int   stall_left = 0;
  int   mismatch_count = 0;

  // shadow copy of the ring
  bit [7:0] shadow_store [RING_BYTES];
  int       shadow_head = 0;
  int       shadow_tail = 0;
  bit       shadow_full = 1'b0;
  int       shadow_len = RING_BYTES;

  byte_ring_record_queue u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_record_data   (in_record_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_popped_record(out_popped_record),
    .out_is_empty     (out_is_empty),
    .out_free_bytes   (out_free_bytes),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // free bytes, with the one-byte gap when the head is ahead of the tail
  function automatic int ring_free();
    if (shadow_full) return 0;
    if (shadow_head <= shadow_tail) return shadow_len - (shadow_tail - shadow_head);
    return shadow_head - shadow_tail - 1;
  endfunction

  function automatic int ring_next(int p);
    p++;
    if (p >= shadow_len) p = 0;
    return p;
  endfunction

  // apply one item to the shadow ring and return its result
  function automatic ring_result_t ring_apply(op_t op, logic [63:0] data);
    ring_result_t r;
    int room;
    r.status = ST_OK;
    r.rec = '0;
    if (op == OP_PUSH) begin
      room = ring_free();
      if (room < RECORD_BYTES) begin
        r.status = ST_NO_SPACE;
      end else begin
        if (room == RECORD_BYTES) shadow_full = 1'b1;
        for (int i = 0; i < RECORD_BYTES; i++) begin
          shadow_store[shadow_tail] = data[8*i +: 8];
          shadow_tail = ring_next(shadow_tail);
        end
      end
    end else begin
      if (!shadow_full && shadow_head == shadow_tail) begin
        r.status = ST_EMPTY;
      end else begin
        for (int i = 0; i < RECORD_BYTES; i++) begin
          r.rec[8*i +: 8] = shadow_store[shadow_head];
          shadow_head = ring_next(shadow_head);
        end
        shadow_full = 1'b0;
      end
    end
    r.empty = !shadow_full && shadow_head == shadow_tail;
    r.freeb = 11'(ring_free());
    return r;
  endfunction

  // sender: bursts of items with random gaps
  always @(negedge clk) begin
    bit       hold;
    ring_op_t nxt;
    hold = in_valid && !in_took;
    if (rst_n && !hold) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() != 0) begin
        nxt = pending_ops.pop_front();
        in_op <= nxt.op;
        in_record_data <= nxt.data;
        hold = 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
    in_valid <= hold;
  end

  // receiver: stall pattern picked at random from four modes
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        out_ready <= ~out_ready;
      end
    endcase
  end

  // check results, then log newly accepted items
  always @(posedge clk) begin
    ring_result_t want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d record %h",
                   $time, out_status, out_popped_record);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            mismatch_count++;
          end
          if (out_popped_record !== want.rec) begin
            $display("%0t: popped_record expected %h actual %h", $time, want.rec,
                     out_popped_record);
            mismatch_count++;
          end
          if (out_is_empty !== want.empty) begin
            $display("%0t: is_empty expected %0d actual %0d", $time, want.empty, out_is_empty);
            mismatch_count++;
          end
          if (out_free_bytes !== want.freeb) begin
            $display("%0t: free_bytes expected %0d actual %0d", $time, want.freeb,
                     out_free_bytes);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(ring_apply(op_t'(in_op), in_record_data));
      end
    end
  end

  task automatic queue_item(op_t op, logic [63:0] data);
    ring_op_t it;
    it.op = op;
    it.data = data;
    pending_ops.push_back(it);
  endtask

  // wait until every item is in and every result out, then let the block settle
  task automatic drain();
    do @(posedge clk); while (pending_ops.size() != 0 || in_valid);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // ring length write; the queue empties, stored bytes stay
  task automatic write_ring_len(logic [CFG_W-1:0] len);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    shadow_len = (len > RING_BYTES) ? RING_BYTES : int'(len);
    shadow_head = 0;
    shadow_tail = 0;
    shadow_full = 1'b0;
  endtask

  initial begin
    int          ring_len;
    int          n_items;
    int          push_pct;
    int          seg;
    bit          big;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // whole store after reset; leave records behind for the length change
    queue_item(OP_POP, 64'h0);
    queue_item(OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_item(OP_PUSH, 64'h0);
    queue_item(OP_PUSH, 64'h0123_4567_89AB_CDEF);
    queue_item(OP_POP, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();

    // ring of exactly one record; the length write must have emptied the queue
    write_ring_len(11'd8);
    queue_item(OP_POP, 64'h0);
    queue_item(OP_PUSH, 64'hA5A5_5A5A_C3C3_3C3C);
    queue_item(OP_PUSH, 64'h1111_2222_3333_4444);
    queue_item(OP_POP, 64'h0);
    drain();

    // zero-length ring
    write_ring_len(11'd0);
    queue_item(OP_PUSH, 64'hDEAD_BEEF_0BAD_F00D);
    queue_item(OP_POP, 64'h0);
    drain();

    // ring shorter than a record
    write_ring_len(11'd5);
    queue_item(OP_PUSH, 64'h8000_0000_0000_0001);
    queue_item(OP_POP, 64'h0);
    drain();

    // length above the store saturates
    write_ring_len(11'h7FF);
    queue_item(OP_PUSH, 64'h7766_5544_3322_1100);
    queue_item(OP_POP, 64'h0);
    drain();

    // record wrapping across the ring end
    write_ring_len(11'd17);
    queue_item(OP_PUSH, 64'h0807_0605_0403_0201);
    queue_item(OP_PUSH, 64'h1817_1615_1413_1211);
    queue_item(OP_POP, 64'h0);
    queue_item(OP_PUSH, 64'h2827_2625_2423_2221);
    queue_item(OP_POP, 64'h0);
    queue_item(OP_POP, 64'h0);
    drain();

    // random phases; push bias swings so rings fill and drain
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      ring_len = (ph == NUM_PHASES - 1) ? $urandom_range(0, 2047) : RING_PLAN[ph];
      write_ring_len(11'(ring_len));
      big = (ring_len >= 512);
      n_items = big ? 250 : 80;
      seg = 0;
      push_pct = 50;
      for (int k = 0; k < n_items; k++) begin
        if (seg == 0) begin
          seg = $urandom_range(4, 40);
          if ($urandom_range(0, 2) == 0) push_pct = 50;
          else push_pct = $urandom_range(0, 1) ? 85 : 15;
        end
        seg--;
        // big rings need a long push run to reach full
        if (big && k < 180) push_pct = 95;
        queue_item(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP,
                   {$urandom, $urandom});
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #15_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
